// ----- design/sup_pkg.sv -----
// Shared types and constants for the shortest unique prefix assigner.
// No dependencies; imported by every module of the block except sup_ram.
`timescale 1ns / 1ps

package sup_pkg;

    localparam int MAX_WORDS  = 1024;
    localparam int MAX_CHARS  = 16;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = $clog2(MAX_CHARS + 1);
    localparam int IDX_W      = $clog2(MAX_WORDS);
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int POS_W      = $clog2(MAX_CHARS);

    // Current word as held by the word buffer
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [LEN_W-1:0]                 len;
    } word_t;

    // One table row: abbreviation length and its bytes
    typedef struct packed {
        logic [LEN_W-1:0]                 len;
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    } entry_t;

    localparam int ROW_W = $bits(entry_t);

    typedef struct packed {
        logic [LEN_W-1:0] prefix_length;
        logic [IDX_W-1:0] entry_index;
        logic             no_unique_prefix;
        logic             table_full;
    } result_t;

endpackage

// ----- design/shortest_unique_prefix_assigner.sv -----
// Shortest unique prefix assigner top level: word buffer, scan controller and
// the abbreviation table RAM. Depends on sup_pkg, sup_ram, sup_word_buf, sup_scan.
`timescale 1ns / 1ps

// Bytes enter on start while busy is low. A byte without last_char is taken
// without raising busy and gives no result. A byte with last_char starts a
// sweep over the table in the scan state, one stored abbreviation per cycle
// through the table RAM read port, over entry_count rows, the number of
// abbreviations stored so far (up to 1024). The pick state follows, and the
// result strobe done is registered out of it. busy stays high from that byte
// through the pick state and falls as done rises. done is high for a single
// cycle and cannot be held off; the result stays on the ports until the next.
// The table needs no clearing after reset: only rows already written are read.
module shortest_unique_prefix_assigner (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sup_pkg::CHAR_W-1:0] char_code,
    input  logic                       last_char,
    output logic                       done,
    output logic [sup_pkg::LEN_W-1:0]  prefix_length,
    output logic [sup_pkg::IDX_W-1:0]  entry_index,
    output logic                       no_unique_prefix,
    output logic                       table_full
);
    import sup_pkg::*;

    logic       accept;
    logic       clear_word;
    word_t      word;
    logic       ram_re;
    logic       ram_we;
    logic [IDX_W-1:0] ram_raddr;
    logic [IDX_W-1:0] ram_waddr;
    entry_t     ram_rdata;
    entry_t     ram_wdata;
    result_t    result;

    assign accept = start && !busy;

    sup_word_buf u_word_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .ch    (char_code),
        .clear (clear_word),
        .word  (word)
    );

    sup_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_WORDS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sup_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (accept && last_char),
        .word       (word),
        .busy       (busy),
        .clear_word (clear_word),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .done       (done),
        .result     (result)
    );

    assign prefix_length    = result.prefix_length;
    assign entry_index      = result.entry_index;
    assign no_unique_prefix = result.no_unique_prefix;
    assign table_full       = result.table_full;

`ifndef SYNTH
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe without end of busy period");

    a_mid_word_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last_char |=> !busy && !done)
        else $error("non-final byte stalled or produced a result");

    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        done && table_full |-> entry_index == '0)
        else $error("full table reported a nonzero slot");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> prefix_length != '0)
        else $error("zero prefix length reported");
`endif

endmodule

// ----- design/sup_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sup_word_buf.sv -----
// Word buffer: collects the bytes of the current word and its length.
// Depends on sup_pkg.
`timescale 1ns / 1ps

module sup_word_buf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [sup_pkg::CHAR_W-1:0]    ch,
    input  logic                          clear,
    output sup_pkg::word_t                word
);
    import sup_pkg::*;

    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_reg;
    logic [LEN_W-1:0]                 len_reg;
    logic [LEN_W-1:0]                 len_next;
    logic                             room;

    assign room = (len_reg < LEN_W'(MAX_CHARS));

    always_comb
    begin
        len_next = len_reg;
        if (clear)
        begin
            len_next = '0;
        end
        else if (push && room)
        begin
            len_next = len_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // Drop bytes past the buffer depth
    always_ff @(posedge clk)
    begin
        if (push && room)
        begin
            chars_reg[len_reg[POS_W-1:0]] <= ch;
        end
    end

    assign word.chars = chars_reg;
    assign word.len   = len_reg;

endmodule

// ----- design/sup_scan.sv -----
// Scan controller: sweeps the abbreviation table, marks taken prefix lengths,
// picks the shortest free prefix and, unless the table is full, writes the new row.
// Depends on sup_pkg; drives the table RAM in the top level.
`timescale 1ns / 1ps

module sup_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  sup_pkg::word_t              word,
    output logic                        busy,
    output logic                        clear_word,
    output logic                        ram_re,
    output logic [sup_pkg::IDX_W-1:0]   ram_raddr,
    input  sup_pkg::entry_t             ram_rdata,
    output logic                        ram_we,
    output logic [sup_pkg::IDX_W-1:0]   ram_waddr,
    output sup_pkg::entry_t             ram_wdata,
    output logic                        done,
    output sup_pkg::result_t            result
);
    import sup_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_PICK = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     rd_addr_reg, rd_addr_next;
    logic                 pend_reg, pend_next;
    logic [MAX_CHARS-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    logic                 issue;
    logic                 row_match;
    logic [MAX_CHARS-1:0] byte_ok;
    logic                 found;
    logic [LEN_W-1:0]     k_sel;
    logic                 full;
    logic [POS_W-1:0]     hit_pos;

    assign issue = (state_reg == ST_SCAN) && (rd_addr_reg < count_reg);
    assign full  = (count_reg == CNT_W'(MAX_WORDS));

    // Taken-length bit of the row being compared
    assign hit_pos = POS_W'(ram_rdata.len - LEN_W'(1));

    // Row matches when its length fits the word and its bytes equal the word prefix
    always_comb
    begin
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            byte_ok[i] = (ram_rdata.chars[i] == word.chars[i]) ||
                         (LEN_W'(i) >= ram_rdata.len);
        end
        row_match = (&byte_ok) && (ram_rdata.len != '0) && (ram_rdata.len <= word.len);
    end

    // Shortest length not taken, up to the word length
    always_comb
    begin
        found = 1'b0;
        k_sel = word.len;
        for (int c = 0; c < MAX_CHARS; c++)
        begin
            if (!found && (LEN_W'(c) < word.len) && !taken_reg[c])
            begin
                found = 1'b1;
                k_sel = LEN_W'(c + 1);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        rd_addr_next = rd_addr_reg;
        pend_next    = pend_reg;
        taken_next   = taken_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[IDX_W-1:0];
        ram_wdata.len   = k_sel;
        ram_wdata.chars = word.chars;
        clear_word   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    rd_addr_next = '0;
                    pend_next    = 1'b0;
                    taken_next   = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                end
                pend_next = issue;
                if (pend_reg && row_match)
                begin
                    taken_next[hit_pos] = 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                result_next.prefix_length    = k_sel;
                result_next.no_unique_prefix = !found;
                result_next.table_full       = full;
                result_next.entry_index      = full ? '0 : count_reg[IDX_W-1:0];
                if (!full)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                clear_word = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_addr_reg <= '0;
            pend_reg    <= 1'b0;
            taken_reg   <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_addr_reg <= rd_addr_next;
            pend_reg    <= pend_next;
            taken_reg   <= taken_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign ram_re    = issue;
    assign ram_raddr = rd_addr_reg[IDX_W-1:0];
    assign done      = done_reg;
    assign result    = result_reg;

endmodule
